/* rtl/rlpl_pkg.sv */
// ----------------------------------------------------------------------------
// rlpl_pkg
// Shared types and codes of the route longest-prefix lookup block.
// ----------------------------------------------------------------------------
package rlpl_pkg;

    // Codes of the action selector on the input stream.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Field widths.
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned OUT_DATA_W = 8;

    // One route table slot as stored in the table memory.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] metric;
    } t_route;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic start;   // new lookup: clear the winner and latch the address
        logic sample;  // table read data is valid this cycle
    } t_cmp_ctrl;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

endpackage

/* rtl/route_longest_prefix_lookup.sv */
// ----------------------------------------------------------------------------
// route_longest_prefix_lookup
// IPv4 route table with a sequential longest-prefix lookup over all slots.
//
//  Channel   Dir  Fields (tdata / tuser)
//  s_axis    in   tdata: index, valid, prefix, mask, metric, address; tuser: action
//  m_axis    out  tdata: hit, best_index
//
// A write's result is loaded into the output register at the accepting edge.
// A lookup reads each slot in turn in the scan state, compares the last slot
// in the drain state and loads its result in the fin state; the next beat can
// be taken back in idle. After reset a clearing pass over all TABLE_DEPTH slots
// zeroes the valid bits, with no beat taken.
// Input waits while busy or while a stalled result holds the output register.
// ----------------------------------------------------------------------------
module route_longest_prefix_lookup #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [5:0] entry_index, [6] entry_valid, [38:7] entry_prefix,
    // [70:39] entry_mask, [102:71] entry_metric, [134:103] lookup_address
    input  logic [135:0] s_axis_tdata,
    // [0] action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] hit, [6:1] best_index
    output logic [7:0]   m_axis_tdata
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned AW = (IW > rlpl_pkg::IDX_W) ? IW : rlpl_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(TABLE_DEPTH);

    // Input fields.
    logic [rlpl_pkg::IDX_W-1:0]  in_index;
    logic                        in_valid;
    logic [rlpl_pkg::ADDR_W-1:0] in_prefix;
    logic [rlpl_pkg::ADDR_W-1:0] in_mask;
    logic [rlpl_pkg::ADDR_W-1:0] in_metric;
    logic [rlpl_pkg::ADDR_W-1:0] in_address;

    assign in_index   = s_axis_tdata[5:0];
    assign in_valid   = s_axis_tdata[6];
    assign in_prefix  = s_axis_tdata[38:7];
    assign in_mask    = s_axis_tdata[70:39];
    assign in_metric  = s_axis_tdata[102:71];
    assign in_address = s_axis_tdata[134:103];

    rlpl_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic             r_out_valid, n_out_valid;
    logic             r_out_hit, n_out_hit;
    logic [rlpl_pkg::IDX_W-1:0] r_out_idx, n_out_idx;

    logic             accept;
    logic             out_free;
    logic             in_range;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    rlpl_pkg::t_route wr_data;
    logic             rd_en;
    rlpl_pkg::t_route rd_data;
    rlpl_pkg::t_cmp_ctrl cmp_ctrl;
    logic             cmp_hit;
    logic [IW-1:0]    cmp_idx;

    // Handshake.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == rlpl_pkg::ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Writes beyond the table are dropped.
    assign in_range = (AW+1)'(in_index) < DEPTH_EXT;

    // Table write port: clearing pass or accepted write beat.
    always_comb begin
        if (r_state == rlpl_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = '0;
        end else begin
            wr_en          = accept && (s_axis_tuser == rlpl_pkg::ACT_WRITE) && in_range;
            wr_addr        = IW'(in_index);
            wr_data.valid  = in_valid;
            wr_data.prefix = in_prefix;
            wr_data.mask   = in_mask;
            wr_data.metric = in_metric;
        end
    end

    assign rd_en = (r_state == rlpl_pkg::ST_SCAN);

    rlpl_table #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt),
        .o_rd_data (rd_data)
    );

    assign cmp_ctrl.start  = accept && (s_axis_tuser == rlpl_pkg::ACT_LOOKUP);
    assign cmp_ctrl.sample = r_rd_vld;

    rlpl_cmp #(
        .IW (IW)
    ) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (cmp_ctrl),
        .i_addr      (in_address),
        .i_entry     (rd_data),
        .i_entry_idx (r_rd_idx),
        .o_hit       (cmp_hit),
        .o_best_idx  (cmp_idx)
    );

    // Sequencer and output register next state.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_hit   = r_out_hit;
        n_out_idx   = r_out_idx;
        case (r_state)
            rlpl_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_cnt   = '0;
                    n_state = rlpl_pkg::ST_IDLE;
                end
            end
            rlpl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == rlpl_pkg::ACT_WRITE) begin
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b0;
                        n_out_idx   = '0;
                    end else begin
                        n_cnt   = '0;
                        n_state = rlpl_pkg::ST_SCAN;
                    end
                end
            end
            rlpl_pkg::ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_cnt   = '0;
                    n_state = rlpl_pkg::ST_DRAIN;
                end
            end
            rlpl_pkg::ST_DRAIN: begin
                n_state = rlpl_pkg::ST_FIN;
            end
            rlpl_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = cmp_hit;
                    n_out_idx   = rlpl_pkg::IDX_W'(cmp_idx);
                    n_state     = rlpl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlpl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlpl_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= r_cnt;
        r_out_hit <= n_out_hit;
        r_out_idx <= n_out_idx;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_idx, r_out_hit};

    // A write beat answers with a miss in the very next cycle.
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == rlpl_pkg::ACT_WRITE)) |=>
            (r_out_valid && !r_out_hit && (r_out_idx == '0)))
        else $error("write beat did not produce a miss result");

    // Read data is only in flight during the scan and drain states.
    a_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == rlpl_pkg::ST_SCAN) || (r_state == rlpl_pkg::ST_DRAIN)))
        else $error("table read data valid outside a lookup scan");

    // A lookup starts its scan at slot zero.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == rlpl_pkg::ACT_LOOKUP)) |=>
            ((r_state == rlpl_pkg::ST_SCAN) && (r_cnt == '0)))
        else $error("lookup did not start its scan at slot zero");

endmodule

/* rtl/rlpl_table.sv */
// ----------------------------------------------------------------------------
// rlpl_table
// Route table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rlpl_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IW    = 6
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  rlpl_pkg::t_route i_wr_data,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_rd_addr,
    output rlpl_pkg::t_route o_rd_data
);

    rlpl_pkg::t_route r_mem [DEPTH];
    rlpl_pkg::t_route r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/rlpl_cmp.sv */
// ----------------------------------------------------------------------------
// rlpl_cmp
// Shared match and compare unit; keeps the running winner of a lookup.
// ----------------------------------------------------------------------------
module rlpl_cmp #(
    parameter int unsigned IW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlpl_pkg::t_cmp_ctrl           i_ctrl,
    input  logic [rlpl_pkg::ADDR_W-1:0]   i_addr,
    input  rlpl_pkg::t_route              i_entry,
    input  logic [IW-1:0]                 i_entry_idx,
    output logic                          o_hit,
    output logic [IW-1:0]                 o_best_idx
);

    logic                        r_found;
    logic [rlpl_pkg::ADDR_W-1:0] r_addr;
    logic [rlpl_pkg::ADDR_W-1:0] r_win_mask;
    logic [rlpl_pkg::ADDR_W-1:0] r_win_metric;
    logic [IW-1:0]               r_win_idx;

    logic match;
    logic better;
    logic take;

    // A valid slot matches when prefix and address agree on every mask bit.
    assign match = i_entry.valid &&
                   (((i_entry.prefix ^ r_addr) & i_entry.mask) == '0);

    // Larger mask wins; on equal masks a strictly smaller metric wins.
    assign better = !r_found || (i_entry.mask > r_win_mask) ||
                    ((i_entry.mask == r_win_mask) && (i_entry.metric < r_win_metric));

    assign take = i_ctrl.sample && match && better;

    // Found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // Lookup address and winner payload.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_addr    <= i_addr;
            r_win_idx <= '0;
        end else if (take) begin
            r_win_mask   <= i_entry.mask;
            r_win_metric <= i_entry.metric;
            r_win_idx    <= i_entry_idx;
        end
    end

    assign o_hit      = r_found;
    assign o_best_idx = r_found ? r_win_idx : '0;

endmodule
